// ===== hdl/bpc_pkg.sv =====
// Shared types, event codes and register map for the button press classifier.
package bpc_pkg;

  localparam int TimeW  = 32;
  localparam int ThrW   = 16;
  localparam int EventW = 2;

  typedef logic [EventW-1:0] event_t;

  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_SHORT  = 2'd1;
  localparam event_t EV_LONG   = 2'd2;
  localparam event_t EV_DOUBLE = 2'd3;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_MIN_PRESS  = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd2;

  localparam logic [ThrW-1:0] MIN_PRESS_RST  = 16'd50;
  localparam logic [ThrW-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [ThrW-1:0] DOUBLE_GAP_RST = 16'd400;

  typedef struct packed {
    logic             prev_level;
    logic [TimeW-1:0] press_start;
    logic [TimeW-1:0] last_release;
    logic             long_seen;
    logic             single_pending;
  } btn_state_t;

  typedef struct packed {
    logic [ThrW-1:0] min_press;
    logic [ThrW-1:0] long_press;
    logic [ThrW-1:0] double_gap;
  } btn_cfg_t;

endpackage

// ===== hdl/bpc_decide.sv =====
// Per-sample classification: next tracking state and event from one sample.
module bpc_decide (
  input  logic                      level,
  input  logic [bpc_pkg::TimeW-1:0] time_now,
  input  bpc_pkg::btn_state_t       cur,
  input  bpc_pkg::btn_cfg_t         cfg,
  output bpc_pkg::btn_state_t       nxt,
  output bpc_pkg::event_t           ev
);
  import bpc_pkg::*;

  logic             press_edge;
  logic             release_edge;
  logic [TimeW-1:0] held_raw;
  logic [TimeW-1:0] held;
  logic [TimeW-1:0] gap;
  logic             is_long;
  logic             is_valid;
  logic             in_window;
  logic             arm_single;
  logic             pend_expired;

  assign press_edge   = !level && cur.prev_level;
  assign release_edge = level && !cur.prev_level;
  assign held_raw     = time_now - cur.press_start;
  // on the press edge the start time becomes now, so the hold is zero
  assign held         = press_edge ? '0 : held_raw;
  assign gap          = time_now - cur.last_release;
  assign is_long      = held >= {{(TimeW-ThrW){1'b0}}, cfg.long_press};
  assign is_valid     = held >= {{(TimeW-ThrW){1'b0}}, cfg.min_press};
  assign in_window    = gap < {{(TimeW-ThrW){1'b0}}, cfg.double_gap};

  always_comb begin
    nxt        = cur;
    ev         = EV_NONE;
    arm_single = 1'b0;
    nxt.prev_level = level;
    if (press_edge) begin
      nxt.press_start = time_now;
      nxt.long_seen   = 1'b0;
    end
    if (release_edge) begin
      if (!cur.long_seen) begin
        if (is_long) begin
          ev = EV_LONG;
        end else if (is_valid) begin
          if (in_window) begin
            ev = EV_DOUBLE;
            nxt.single_pending = 1'b0;
          end else begin
            arm_single         = 1'b1;
            nxt.single_pending = 1'b1;
            nxt.last_release   = time_now;
          end
        end
      end
      nxt.long_seen = 1'b0;
    end
    if (!level && !nxt.long_seen && is_long) begin
      ev            = EV_LONG;
      nxt.long_seen = 1'b1;
    end
    // a just-armed single has zero elapsed gap
    pend_expired = arm_single ? (cfg.double_gap == '0) : !in_window;
    if (nxt.single_pending && pend_expired) begin
      ev                 = EV_SHORT;
      nxt.single_pending = 1'b0;
    end
  end

endmodule

// ===== hdl/button_press_classifier_top.sv =====
// Top level of the button press classifier: stream ports, config registers, pipeline.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[0] button_level, [32:1] time_now
//  out_    | out | out_tvalid/tready  | tdata[1:0] press_event
//  cfg_    | in  | APB, pready high   | 0x0 min_press, 0x4 long_press, 0x8 double_gap
//
// One beat per cycle sustained while out_tready holds high. A sample is captured in
// the input register, then the classifier updates the tracking state and loads the
// result register, which drives out_.
// rst_n (synchronous) restores released level, zero times and default thresholds.
// An out_ stall holds the result register; one more sample is then held in the
// input register before in_tready drops.
module button_press_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [0] button_level, [32:1] time_now, [39:33] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [1:0] press_event, [7:2] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpc_pkg::*;

  // configuration registers
  btn_cfg_t cfg_r;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press  <= MIN_PRESS_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.double_gap <= DOUBLE_GAP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MIN_PRESS:  cfg_r.min_press  <= cfg_pwdata[ThrW-1:0];
        REG_LONG_PRESS: cfg_r.long_press <= cfg_pwdata[ThrW-1:0];
        REG_DOUBLE_GAP: cfg_r.double_gap <= cfg_pwdata[ThrW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MIN_PRESS:  cfg_prdata = {{(32-ThrW){1'b0}}, cfg_r.min_press};
      REG_LONG_PRESS: cfg_prdata = {{(32-ThrW){1'b0}}, cfg_r.long_press};
      REG_DOUBLE_GAP: cfg_prdata = {{(32-ThrW){1'b0}}, cfg_r.double_gap};
      default:        cfg_prdata = '0;
    endcase
  end

  // input register
  logic             s1_valid_r;
  logic             s1_level_r;
  logic [TimeW-1:0] s1_time_r;
  logic             advance;
  logic             in_beat;
  logic             upd;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;
  assign upd       = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_level_r <= in_tdata[0];
      s1_time_r  <= in_tdata[TimeW:1];
    end
  end

  // tracking state and classifier
  btn_state_t st_r;
  btn_state_t st_nxt;
  event_t     ev_nxt;

  bpc_decide u_decide (
    .level    (s1_level_r),
    .time_now (s1_time_r),
    .cur      (st_r),
    .cfg      (cfg_r),
    .nxt      (st_nxt),
    .ev       (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.prev_level     <= 1'b1;
      st_r.press_start    <= '0;
      st_r.last_release   <= '0;
      st_r.long_seen      <= 1'b0;
      st_r.single_pending <= 1'b0;
    end else if (upd) begin
      st_r <= st_nxt;
    end
  end

  // result register
  logic   out_valid_r;
  event_t out_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_ev_r <= ev_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-EventW){1'b0}}, out_ev_r};

  // checks
  a_long_only_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.long_seen |-> !st_r.prev_level)
    else $error("long press flag set while released");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && ev_nxt == EV_SHORT) |=> !st_r.single_pending)
    else $error("pending single left armed after a short press");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a sample");

endmodule
